// ----- rtl/mtpm_pkg.sv -----
// ----------------------------------------------------------------------------
// mtpm_pkg: shared types and constants for the stride-4 trie prefix matcher
// Node pool size, derived widths and the front-to-back command record.
// ----------------------------------------------------------------------------
package mtpm_pkg;

  localparam int NODE_COUNT = 1024;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int FREE_W     = NODE_W + 1;
  localparam int POS_W      = NODE_W + 4;
  localparam int ENTRIES    = NODE_COUNT * 16;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // command handed from the front end to the walker
  typedef struct packed {
    logic        lookup;   // lookup when set, insert otherwise
    logic        nop;      // length out of range (0 or above 32); only inserts act on it
    logic [31:0] address;
    logic [5:0]  prefix_len;
    logic [2:0]  last_level; // level holding the marked slot group
    logic [3:0]  first_slot; // aligned start of the group
    logic [3:0]  last_slot;  // end of the group
  } cmd_t;

  // result handed from the walker to the output queue
  typedef struct packed {
    logic [5:0] match_len;
    logic       status;
  } res_t;

endpackage

// ----- rtl/mtpm_front.sv -----
// ----------------------------------------------------------------------------
// mtpm_front: input classification and command queue
// Decodes each transaction into a walk command and buffers two of them.
// ----------------------------------------------------------------------------
module mtpm_front import mtpm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        func,
  input  logic [31:0] address,
  input  logic [5:0]  prefix_len,
  output logic        cmd_valid,
  input  logic        cmd_take,
  output cmd_t        cmd
);

  cmd_t       q [2];
  logic [1:0] count;
  logic       rd_ptr;
  logic       wr_ptr;
  cmd_t       dec;
  logic [5:0] lm1;
  logic [3:0] span_mask;

  // classify the incoming transaction
  always_comb begin
    lm1 = prefix_len - 6'd1;
    unique case (prefix_len[1:0])
      2'd1:    span_mask = 4'h7;
      2'd2:    span_mask = 4'h3;
      2'd3:    span_mask = 4'h1;
      default: span_mask = 4'h0;
    endcase
    dec.lookup     = (func == FUNC_LOOKUP);
    dec.nop        = (prefix_len == 6'd0) || (prefix_len > 6'd32);
    dec.address    = address;
    dec.prefix_len = prefix_len;
    dec.last_level = lm1[4:2];
    dec.first_slot = address[5'd28 - {lm1[4:2], 2'b00} +: 4] & ~span_mask;
    dec.last_slot  = dec.first_slot | span_mask;
  end

  assign full      = count[1];
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];

  // two-entry queue
  always_ff @(posedge clk) begin
    if (push && !full) q[wr_ptr] <= dec;
    if (rst) begin
      count  <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (cmd_take && cmd_valid) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push && !full} - {1'b0, cmd_take && cmd_valid};
    end
  end

endmodule

// ----- rtl/mtpm_back.sv -----
// ----------------------------------------------------------------------------
// mtpm_back: trie walker
// Walks node memory one level at a time (read, then evaluate), marks slot groups on insert.
// Clears node memory after reset, one entry a cycle.
// ----------------------------------------------------------------------------
module mtpm_back import mtpm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_take,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_MARK  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  // entry: present bit, length, child
  localparam int ENT_W = 1 + 6 + NODE_W;

  logic [ENT_W-1:0] mem [ENTRIES];
  logic [ENT_W-1:0] rd_data;
  logic [2:0]       state;
  logic [POS_W-1:0] clr_pos;
  logic [NODE_W-1:0] node;
  logic [2:0]       level;
  logic [3:0]       slot;
  logic [5:0]       found;
  logic [FREE_W-1:0] next_free;
  cmd_t             c;
  logic             we;
  logic [POS_W-1:0] wpos;
  logic [ENT_W-1:0] wdata;
  logic [POS_W-1:0] rpos;
  logic [3:0]       nib;
  logic             e_pres;
  logic [5:0]       e_len;
  logic [NODE_W-1:0] e_child;
  logic             at_mark;

  assign nib     = c.address[5'd28 - {level, 2'b00} +: 4];
  assign rpos    = {node, nib};
  assign e_pres  = rd_data[ENT_W-1];
  assign e_len   = rd_data[ENT_W-2 -: 6];
  assign e_child = rd_data[NODE_W-1:0];
  assign cmd_take = (state == S_IDLE) && cmd_valid;
  // insert has reached the node that holds the slot group
  assign at_mark = !c.lookup && (level == c.last_level);

  // write port selection
  always_comb begin
    we    = 1'b0;
    wpos  = rpos;
    wdata = rd_data;
    unique case (state)
      S_CLEAR: begin
        we = 1'b1; wpos = clr_pos; wdata = '0;
      end
      S_EVAL: begin
        if (!c.lookup && level != c.last_level && e_child == '0
            && next_free < FREE_W'(NODE_COUNT)) begin
          we    = 1'b1;
          wdata = {e_pres, e_len, next_free[NODE_W-1:0]};
        end
      end
      S_MARK: begin
        we    = 1'b1;
        wpos  = {node, slot};
        wdata = {1'b1, (e_len < c.prefix_len) ? c.prefix_len : e_len, e_child};
      end
      default: we = 1'b0;
    endcase
  end

  // node memory, registered read
  always_ff @(posedge clk) begin
    if (we) mem[wpos] <= wdata;
    rd_data <= mem[at_mark ? {node, slot} : rpos];
  end

  // walk sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_pos   <= '0;
      next_free <= FREE_W'(1);
      res_valid <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_pos <= clr_pos + 1'b1;
          if (clr_pos == POS_W'(ENTRIES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_valid) begin
            c     <= cmd;
            node  <= '0;
            level <= '0;
            found <= '0;
            slot  <= cmd.first_slot;
            if (!cmd.lookup && cmd.nop) begin
              res       <= '0;
              res_valid <= 1'b1;
              state     <= S_DONE;
            end else begin
              state <= S_READ;
            end
          end
        end
        // slot group reads go straight to marking
        S_READ: state <= at_mark ? S_MARK : S_EVAL;
        S_EVAL: begin
          if (c.lookup) begin
            if (e_pres) found <= e_len;
            if (e_child == '0 || level == 3'd7) begin
              res       <= '{match_len: e_pres ? e_len : found, status: 1'b0};
              res_valid <= 1'b1;
              state     <= S_DONE;
            end else begin
              node  <= e_child;
              level <= level + 3'd1;
              state <= S_READ;
            end
          end else if (level == c.last_level) begin
            state <= S_MARK;
          end else if (e_child != '0) begin
            node  <= e_child;
            level <= level + 3'd1;
            state <= S_READ;
          end else if (next_free < FREE_W'(NODE_COUNT)) begin
            node      <= next_free[NODE_W-1:0];
            next_free <= next_free + 1'b1;
            level     <= level + 3'd1;
            state     <= S_READ;
          end else begin
            res       <= '{match_len: 6'd0, status: 1'b1};
            res_valid <= 1'b1;
            state     <= S_DONE;
          end
        end
        S_MARK: begin
          // rd_data holds the entry at slot; next read is slot+1
          slot <= slot + 4'd1;
          if (slot == c.last_slot) begin
            res       <= '0;
            res_valid <= 1'b1;
            state     <= S_DONE;
          end else begin
            state <= S_READ;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            res_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/mtpm_out.sv -----
// ----------------------------------------------------------------------------
// mtpm_out: result queue
// Two-entry queue presenting the oldest result to the consumer.
// ----------------------------------------------------------------------------
module mtpm_out import mtpm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       res_valid,
  output logic       res_ready,
  input  res_t       res,
  output logic       empty,
  input  logic       pop,
  output logic [5:0] match_len,
  output logic       status
);

  res_t       q [2];
  logic [1:0] count;
  logic       rd_ptr;
  logic       wr_ptr;
  logic       wr;
  logic       rd;

  assign res_ready = !count[1];
  assign wr        = res_valid && res_ready;
  assign rd        = pop && !empty;
  assign empty     = (count == 2'd0);
  assign match_len = q[rd_ptr].match_len;
  assign status    = q[rd_ptr].status;

  always_ff @(posedge clk) begin
    if (wr) q[wr_ptr] <= res;
    if (rst) begin
      count  <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (wr) wr_ptr <= ~wr_ptr;
      if (rd) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

// ----- rtl/multibit_trie_prefix_match_top.sv -----
// ----------------------------------------------------------------------------
// multibit_trie_prefix_match_top: IPv4 longest-prefix match, stride-4 trie
// Front queue, trie walker over node memory, result queue.
// ----------------------------------------------------------------------------
//  channel  | signals                       | handshake
//  input    | func, address, prefix_len     | push / full
//  result   | match_len, status             | pop / empty
//
//  A lookup reads and evaluates one node entry per level visited (1..8 levels);
//  an insert does so per level walked, then marks each slot of its group (1..8),
//  via the single read/write port of node memory. After reset the walker clears
//  all 16384 node memory entries, then takes transactions; full stays low while
//  the two-entry input queue has room. A stalled result queue stalls the walker.
module multibit_trie_prefix_match_top import mtpm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       func,
  input  logic [31:0] address,
  input  logic [5:0] prefix_len,
  output logic       empty,
  input  logic       pop,
  output logic [5:0] match_len,
  output logic       status
);

  cmd_t cmd;
  res_t res;
  logic cmd_valid;
  logic cmd_take;
  logic res_valid;
  logic res_ready;

  mtpm_front u_front (
    .clk, .rst, .push, .full, .func, .address, .prefix_len,
    .cmd_valid, .cmd_take, .cmd
  );

  mtpm_back u_back (
    .clk, .rst, .cmd_valid, .cmd_take, .cmd, .res_valid, .res_ready, .res
  );

  mtpm_out u_out (
    .clk, .rst, .res_valid, .res_ready, .res, .empty, .pop, .match_len, .status
  );

`ifndef SYNTHESIS
  // a set status always comes with a zero match length
  a_status_lookup: assert property (@(posedge clk) disable iff (rst)
    !empty && status |-> match_len == 6'd0)
    else $error("status set with non-zero length");

  // results stay in range
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> match_len <= 6'd32)
    else $error("match length out of range");

  // walker takes no command while a result is pending
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !cmd_take)
    else $error("command taken while result pending");
`endif

endmodule

// ----- tb/multibit_trie_prefix_match_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multibit_trie_prefix_match_top_tb: self-checking bench for the trie matcher
// Drives inserts and lookups through the push/full queue port. A shadow trie
// predicts each result, and a scoreboard checks what comes out of pop/empty.
// ----------------------------------------------------------------------------
module multibit_trie_prefix_match_top_tb;
  import mtpm_pkg::*;

  localparam int LIMIT_CYCLES = 400000;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic        func;
  logic [31:0] address;
  logic [5:0]  prefix_len;
  logic        empty;
  logic        pop;
  logic [5:0]  match_len;
  logic        status;

  multibit_trie_prefix_match_top u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .func(func),
    .address(address), .prefix_len(prefix_len), .empty(empty), .pop(pop),
    .match_len(match_len), .status(status)
  );

  // shadow trie and store of awaited results
  class trie_scoreboard;
    logic [15:0]       marked [NODE_COUNT];
    logic [5:0]        stored_len [ENTRIES];
    int unsigned       child [ENTRIES];
    int unsigned       free_node;
    res_t              awaited [$];
    int                errors;
    int                inserts;
    int                lookups;
    int                hits;
    int                pool_full;

    function new();
      foreach (marked[i]) marked[i] = '0;
      foreach (stored_len[i]) stored_len[i] = '0;
      foreach (child[i]) child[i] = 0;
      free_node = 1;
      errors = 0;
      inserts = 0;
      lookups = 0;
      hits = 0;
      pool_full = 0;
    endfunction

    function automatic logic [3:0] nib(logic [31:0] a, int unsigned lvl);
      return a[28 - 4 * lvl +: 4];
    endfunction

    function automatic logic add_prefix(logic [31:0] a, int unsigned len);
      int unsigned node;
      int unsigned lvl;
      int unsigned span;
      int unsigned first;
      int unsigned pos;
      node = 0;
      lvl = 0;
      if (len == 0 || len > 32) return 1'b0;
      while (4 * (lvl + 1) < len) begin
        pos = node * 16 + nib(a, lvl);
        if (child[pos] == 0) begin
          if (free_node >= NODE_COUNT) return 1'b1;
          child[pos] = free_node;
          free_node++;
        end
        node = child[pos];
        lvl++;
      end
      span = (len % 4) ? (1 << (4 - len % 4)) : 1;
      first = nib(a, lvl) & ~(span - 1) & 4'hF;
      for (int unsigned i = 0; i < span; i++) begin
        pos = node * 16 + first + i;
        marked[node][first + i] = 1'b1;
        if (stored_len[pos] < len) stored_len[pos] = len[5:0];
      end
      return 1'b0;
    endfunction

    function automatic logic [5:0] longest_match(logic [31:0] a);
      int unsigned node;
      int unsigned pos;
      logic [3:0]  v;
      logic [5:0]  found;
      node = 0;
      found = '0;
      for (int unsigned lvl = 0; lvl < 8; lvl++) begin
        v = nib(a, lvl);
        pos = node * 16 + v;
        if (marked[node][v]) found = stored_len[pos];
        node = child[pos];
        if (node == 0) break;
      end
      return found;
    endfunction

    // note an accepted input transaction
    function void note_input(logic f, logic [31:0] a, logic [5:0] len);
      res_t r;
      if (f == FUNC_INSERT) begin
        r.match_len = '0;
        r.status = add_prefix(a, len);
        inserts++;
        if (r.status) pool_full++;
      end else begin
        r.match_len = longest_match(a);
        r.status = 1'b0;
        lookups++;
        if (r.match_len != 0) hits++;
      end
      awaited.push_back(r);
    endfunction

    // check an accepted result transaction against the oldest awaited one
    function void check_result(logic [5:0] ml, logic st);
      res_t e;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result match_len=%0d status=%0d", $time, ml, st);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (ml !== e.match_len) begin
        $display("%0t: match_len expected %0d actual %0d", $time, e.match_len, ml);
        errors++;
      end
      if (st !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
    endfunction
  endclass

  trie_scoreboard sb;
  int unsigned    cycle_count;
  bit             calm;   // no idling on either side while set

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: random pop stalls, check on each accepted transaction
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) sb.check_result(match_len, status);
      pop <= calm ? 1'b1 : ($urandom_range(99) >= 29);
    end
  end

  // present one transaction and hold it until accepted; push is left high
  task automatic send(logic f, logic [31:0] a, logic [5:0] len);
    while (!calm && $urandom_range(99) < 29) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    func <= f;
    address <= a;
    prefix_len <= len;
    do @(posedge clk); while (full);
    sb.note_input(f, a, len);
  endtask

  function automatic logic [31:0] pick_addr(logic [31:0] bases [$]);
    logic [31:0] a;
    a = $urandom();
    if (bases.size() > 0 && $urandom_range(3) != 0)
      a = bases[$urandom_range(bases.size() - 1)] ^ ($urandom() >> $urandom_range(32));
    return a;
  endfunction

  initial begin
    logic [31:0] bases [$];
    logic [31:0] a;
    logic [5:0]  len;
    int          k;
    sb = new();
    cycle_count = 0;
    calm = 1'b0;
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    func = FUNC_INSERT;
    address = '0;
    prefix_len = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, host bits, zero and oversized lengths, repeats
    send(FUNC_LOOKUP, 32'h0000_0000, 6'd0);
    send(FUNC_INSERT, 32'hFFFF_FFFF, 6'd1);
    send(FUNC_INSERT, 32'h0000_0000, 6'd32);
    send(FUNC_INSERT, 32'hFFFF_FFFF, 6'd32);
    send(FUNC_INSERT, 32'h0A0B_CDEF, 6'd8);
    send(FUNC_INSERT, 32'h0A0B_CDEF, 6'd8);
    send(FUNC_INSERT, 32'h0A0F_FFFF, 6'd13);
    send(FUNC_INSERT, 32'h0A00_0000, 6'd4);
    send(FUNC_INSERT, 32'h1234_5678, 6'd0);
    send(FUNC_INSERT, 32'h1234_5678, 6'd33);
    send(FUNC_INSERT, 32'h1234_5678, 6'd63);
    send(FUNC_INSERT, 32'hC0A8_0100, 6'd24);
    send(FUNC_INSERT, 32'hC0A8_01FF, 6'd27);
    send(FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd63);
    send(FUNC_LOOKUP, 32'h0000_0000, 6'd0);
    send(FUNC_LOOKUP, 32'h7FFF_FFFF, 6'd5);
    send(FUNC_LOOKUP, 32'h0A0B_0000, 6'd0);
    send(FUNC_LOOKUP, 32'h0A08_1234, 6'd0);
    send(FUNC_LOOKUP, 32'h0A1B_0000, 6'd0);
    send(FUNC_LOOKUP, 32'hC0A8_01E0, 6'd0);
    send(FUNC_LOOKUP, 32'hC0A8_0110, 6'd0);
    bases.push_back(32'h0A0B_CDEF);
    bases.push_back(32'hC0A8_0100);

    // random: mostly lookups near known prefixes, inserts with any length
    for (k = 0; k < 260; k++) begin
      calm = (k >= 80 && k < 130);
      a = pick_addr(bases);
      if ($urandom_range(99) < 45) begin
        len = ($urandom_range(19) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(1, 32));
        send(FUNC_INSERT, a, len);
        if (bases.size() < 64) bases.push_back(a);
      end else begin
        send(FUNC_LOOKUP, a, 6'($urandom_range(63)));
      end
    end

    // drive the node pool to exhaustion with deep scattered prefixes
    k = 0;
    while (sb.pool_full < 4 && k < 400) begin
      send(FUNC_INSERT, $urandom(), 6'd32);
      k++;
    end
    for (k = 0; k < 60; k++) send(FUNC_LOOKUP, pick_addr(bases), 6'd0);
    send(FUNC_INSERT, 32'h0A0B_CDEF, 6'd12);
    send(FUNC_LOOKUP, 32'h0A0B_CDEF, 6'd0);
    push <= 1'b0;

    // drain
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Covered %0d inserts (%0d refused for a full pool) and %0d lookups, %0d hits.",
             sb.inserts, sb.pool_full, sb.lookups, sb.hits);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/mtpm_pkg.sv
rtl/mtpm_front.sv
rtl/mtpm_back.sv
rtl/mtpm_out.sv
rtl/multibit_trie_prefix_match_top.sv
tb/multibit_trie_prefix_match_top_tb.sv
